FILE: sv/address_range_allocator_core_defines.svh
// Assertion macros used by the allocator RTL
`ifndef ADDRESS_RANGE_ALLOCATOR_CORE_DEFINES_SVH
`define ADDRESS_RANGE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define ARAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/arac_pkg.sv
// Shared constants, codes and types of the range allocator
package arac_pkg;

    localparam int FREE_RANGES = 64;
    localparam int USED_RANGES = 64;
    localparam int PAGE_BITS   = 36;

    localparam int SCAN_LEN = (FREE_RANGES > USED_RANGES) ? FREE_RANGES : USED_RANGES;
    localparam int FREE_AW  = (FREE_RANGES > 1) ? $clog2(FREE_RANGES) : 1;
    localparam int USED_AW  = (USED_RANGES > 1) ? $clog2(USED_RANGES) : 1;
    localparam int SCAN_AW  = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_EXACT = 2'd2;
    localparam logic [1:0] MODE_FREE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_NOT_FREE = 3'd2;
    localparam logic [2:0] ST_NO_FIT   = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic sel;      // entry becomes the best allocation candidate
        logic hi_upd;   // entry becomes the right neighbour
        logic lo_upd;   // entry becomes the left neighbour
    } t_cmp_flags;

endpackage

FILE: sv/address_range_allocator_core.sv
// Top level of the first-fit range allocator with coalescing
//
//  channel   signals                                            direction
//  request   start, busy (out), i_mode, i_start_page,          in
//            i_length_pages, i_align_log2
//  result    o_valid, o_status, o_alloc_page                    out
//
// A request holds busy high through the scan: one read of both tables
// per cycle through a single compare unit, behind the read data registers
// and a second register stage, then the write-back states S_WR1 and S_WR2.
// The result is shown for one cycle on o_valid as busy falls, so the next
// request can be taken at the edge that ends it; none is taken while busy.
// The receiver cannot stall. Synchronous active-low reset empties both tables
// via their valid bits.
`include "address_range_allocator_core_defines.svh"

module address_range_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_mode,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_start_page,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_length_pages,
    input  logic [5:0]                     i_align_log2,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic [arac_pkg::PAGE_BITS-1:0] o_alloc_page
);

    localparam int PB = arac_pkg::PAGE_BITS;
    localparam int FA = arac_pkg::FREE_AW;
    localparam int UA = arac_pkg::USED_AW;
    localparam int SA = arac_pkg::SCAN_AW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WR1  = 2'd2;
    localparam logic [1:0] S_WR2  = 2'd3;

    logic [PB-1:0] free_start_mem [arac_pkg::FREE_RANGES];
    logic [PB-1:0] free_end_mem   [arac_pkg::FREE_RANGES];
    logic [PB-1:0] used_start_mem [arac_pkg::USED_RANGES];
    logic [PB-1:0] used_end_mem   [arac_pkg::USED_RANGES];

    logic [arac_pkg::FREE_RANGES-1:0] r_free_v;
    logic [arac_pkg::USED_RANGES-1:0] r_used_v;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_mode;
    logic [PB-1:0] r_s, r_len;
    logic [PB:0]   r_e;
    logic [5:0]    r_al;
    logic          r_bad;

    logic          r_iss, r_v1, r_v2;
    logic [SA-1:0] r_idx, r_i1, r_i2;

    logic [PB-1:0] r_fs_rd, r_fe_rd, r_us_rd, r_ue_rd;
    logic [PB-1:0] r_fs2, r_fe2, r_us2, r_ue2;
    logic [PB:0]   r_a2;
    logic          r_over2;

    logic          r_best_found, r_lo_found, r_hi_found;
    logic [FA-1:0] r_best_idx, r_lo_idx, r_hi_idx, r_fn_idx;
    logic [PB-1:0] r_best_s, r_best_e, r_best_a, r_best_ae;
    logic [PB-1:0] r_lo_s, r_lo_e, r_hi_s, r_hi_e;
    logic          r_fn_found, r_un_found, r_um_found;
    logic [UA-1:0] r_un_idx, r_um_idx;

    logic          r_wr2;
    logic          r_valid;
    logic [2:0]    r_status;
    logic [PB-1:0] r_page;

    // stage-1 alignment
    logic [PB:0]   a1;
    logic          over1;
    logic [PB-1:0] amask;
    logic [PB:0]   asum;

    always_comb begin
        amask = '0;
        asum  = '0;
        if (r_al >= 6'(PB)) begin
            // alignment beyond the page space: only a zero start stays put
            a1    = '0;
            over1 = r_fs_rd != '0;
        end else begin
            amask = (PB'(1) << r_al) - PB'(1);
            asum  = {1'b0, r_fs_rd} + {1'b0, amask};
            a1    = asum & ~{1'b0, amask};
            over1 = 1'b0;
        end
    end

    logic                 in_free2, in_used2, fv2, uv2;
    logic [FA-1:0]        i2f;
    logic [UA-1:0]        i2u;
    arac_pkg::t_cmp_flags cf;
    logic [PB-1:0]        c_as, c_ae;

    assign i2f      = r_i2[FA-1:0];
    assign i2u      = r_i2[UA-1:0];
    assign in_free2 = {1'b0, r_i2} < (SA+1)'(arac_pkg::FREE_RANGES);
    assign in_used2 = {1'b0, r_i2} < (SA+1)'(arac_pkg::USED_RANGES);
    assign fv2      = in_free2 && r_free_v[i2f];
    assign uv2      = in_used2 && r_used_v[i2u];

    arac_cmp u_cmp (
        .i_mode       (r_mode),
        .i_entry_valid(fv2),
        .i_fs         (r_fs2),
        .i_fe         (r_fe2),
        .i_a          (r_a2),
        .i_a_over     (r_over2),
        .i_s          (r_s),
        .i_e          (r_e),
        .i_len        (r_len),
        .i_best_found (r_best_found),
        .i_best_s     (r_best_s),
        .i_lo_found   (r_lo_found),
        .i_lo_s       (r_lo_s),
        .i_hi_found   (r_hi_found),
        .i_hi_s       (r_hi_s),
        .o_flags      (cf),
        .o_a_start    (c_as),
        .o_a_end      (c_ae)
    );

    // write-back decisions
    logic       mlo, mhi, ins_new, ins_full, left, right, both, car_full;
    logic       ok, do_ins, do_car;
    logic [2:0] status_w;

    always_comb begin
        mlo      = r_lo_found && (r_lo_e == r_s);
        mhi      = r_hi_found && (r_hi_s == r_e[PB-1:0]);
        ins_new  = !mlo && !mhi;
        ins_full = ins_new && !r_fn_found;
        left     = r_best_s < r_best_a;
        right    = r_best_ae < r_best_e;
        both     = left && right;
        car_full = !r_un_found || (both && !r_fn_found);
        if (r_bad) begin
            status_w = arac_pkg::ST_BAD_LEN;
        end else begin
            unique case (r_mode)
                arac_pkg::MODE_ADD:   status_w = ins_full ? arac_pkg::ST_FULL : arac_pkg::ST_OK;
                arac_pkg::MODE_FIRST: status_w = !r_best_found ? arac_pkg::ST_NO_FIT :
                                                 car_full ? arac_pkg::ST_FULL : arac_pkg::ST_OK;
                arac_pkg::MODE_EXACT: status_w = !r_best_found ? arac_pkg::ST_NOT_FREE :
                                                 car_full ? arac_pkg::ST_FULL : arac_pkg::ST_OK;
                default:              status_w = !r_um_found ? arac_pkg::ST_MISMATCH :
                                                 ins_full ? arac_pkg::ST_FULL : arac_pkg::ST_OK;
            endcase
        end
        ok     = (r_state == S_WR1) && (status_w == arac_pkg::ST_OK);
        do_ins = ok && (r_mode == arac_pkg::MODE_ADD || r_mode == arac_pkg::MODE_FREE);
        do_car = ok && (r_mode == arac_pkg::MODE_FIRST || r_mode == arac_pkg::MODE_EXACT);
    end

    // memory write ports
    logic          fs_we, fe_we, u_we;
    logic [FA-1:0] fs_wa, fe_wa;
    logic [PB-1:0] fs_wd, fe_wd;

    always_comb begin
        fs_we = 1'b0;
        fs_wa = r_fn_idx;
        fs_wd = r_s;
        fe_we = 1'b0;
        fe_wa = r_fn_idx;
        fe_wd = r_e[PB-1:0];
        if (do_ins) begin
            if (mhi && !mlo) begin
                fs_we = 1'b1;
                fs_wa = r_hi_idx;
            end else if (ins_new) begin
                fs_we = 1'b1;
            end
            if (mlo) begin
                fe_we = 1'b1;
                fe_wa = r_lo_idx;
                fe_wd = mhi ? r_hi_e : r_e[PB-1:0];
            end else if (ins_new) begin
                fe_we = 1'b1;
            end
        end else if (do_car) begin
            if (both) begin
                fs_we = 1'b1;
                fs_wd = r_best_ae;
            end else if (right) begin
                fs_we = 1'b1;
                fs_wa = r_best_idx;
                fs_wd = r_best_ae;
            end
            if (left) begin
                fe_we = 1'b1;
                fe_wa = r_best_idx;
                fe_wd = r_best_a;
            end
        end else if (r_state == S_WR2 && r_wr2) begin
            // right remainder keeps the old end
            fe_we = 1'b1;
            fe_wd = r_best_e;
        end
        u_we = do_car;
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) free_start_mem[fs_wa] <= fs_wd;
        if (fe_we) free_end_mem[fe_wa] <= fe_wd;
        if (u_we) begin
            used_start_mem[r_un_idx] <= r_best_a;
            used_end_mem[r_un_idx]   <= r_best_ae;
        end
        r_fs_rd <= free_start_mem[r_idx[FA-1:0]];
        r_fe_rd <= free_end_mem[r_idx[FA-1:0]];
        r_us_rd <= used_start_mem[r_idx[UA-1:0]];
        r_ue_rd <= used_end_mem[r_idx[UA-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_SCAN;
            S_SCAN:  if (r_v2 && r_i2 == SA'(arac_pkg::SCAN_LEN - 1)) n_state = S_WR1;
            S_WR1:   n_state = S_WR2;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free_v <= '0;
            r_used_v <= '0;
            r_iss    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_valid  <= 1'b0;
            r_wr2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= r_state == S_WR2;
            r_v1    <= r_iss;
            r_v2    <= r_v1;
            if (r_iss) begin
                r_idx <= r_idx + SA'(1);
                if (r_idx == SA'(arac_pkg::SCAN_LEN - 1)) r_iss <= 1'b0;
            end
            if (r_state == S_IDLE && start) begin
                r_iss <= 1'b1;
                r_idx <= '0;
            end
            if (r_state == S_WR1) begin
                r_wr2    <= do_car && both;
                r_status <= status_w;
                r_page   <= do_car ? r_best_a : '0;
                if (do_ins) begin
                    if (mlo && mhi) r_free_v[r_hi_idx] <= 1'b0;
                    else if (ins_new) r_free_v[r_fn_idx] <= 1'b1;
                    if (r_mode == arac_pkg::MODE_FREE) r_used_v[r_um_idx] <= 1'b0;
                end
                if (do_car) begin
                    if (both) r_free_v[r_fn_idx] <= 1'b1;
                    else if (!left && !right) r_free_v[r_best_idx] <= 1'b0;
                    r_used_v[r_un_idx] <= 1'b1;
                end
            end
        end
    end

    // request capture and scan datapath
    always_ff @(posedge i_clk) begin
        r_i1    <= r_idx;
        r_i2    <= r_i1;
        r_a2    <= a1;
        r_over2 <= over1;
        r_fs2   <= r_fs_rd;
        r_fe2   <= r_fe_rd;
        r_us2   <= r_us_rd;
        r_ue2   <= r_ue_rd;
        if (r_state == S_IDLE && start) begin
            r_mode       <= i_mode;
            r_s          <= i_start_page;
            r_len        <= i_length_pages;
            r_al         <= i_align_log2;
            r_e          <= {1'b0, i_start_page} + {1'b0, i_length_pages};
            r_bad        <= (i_length_pages == '0) || (i_mode != arac_pkg::MODE_FIRST &&
                            ({1'b0, i_start_page} + {1'b0, i_length_pages}) > {1'b0, {PB{1'b1}}});
            r_best_found <= 1'b0;
            r_lo_found   <= 1'b0;
            r_hi_found   <= 1'b0;
            r_fn_found   <= 1'b0;
            r_un_found   <= 1'b0;
            r_um_found   <= 1'b0;
        end else if (r_v2) begin
            if (cf.sel) begin
                r_best_found <= 1'b1;
                r_best_idx   <= i2f;
                r_best_s     <= r_fs2;
                r_best_e     <= r_fe2;
                r_best_a     <= c_as;
                r_best_ae    <= c_ae;
            end
            if (cf.hi_upd) begin
                r_hi_found <= 1'b1;
                r_hi_idx   <= i2f;
                r_hi_s     <= r_fs2;
                r_hi_e     <= r_fe2;
            end
            if (cf.lo_upd) begin
                r_lo_found <= 1'b1;
                r_lo_idx   <= i2f;
                r_lo_s     <= r_fs2;
                r_lo_e     <= r_fe2;
            end
            if (in_free2 && !fv2 && !r_fn_found) begin
                r_fn_found <= 1'b1;
                r_fn_idx   <= i2f;
            end
            if (in_used2 && !uv2 && !r_un_found) begin
                r_un_found <= 1'b1;
                r_un_idx   <= i2u;
            end
            if (uv2 && !r_um_found && r_us2 == r_s && {1'b0, r_ue2} == r_e) begin
                r_um_found <= 1'b1;
                r_um_idx   <= i2u;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_alloc_page = r_page;

    `ARAC_ASSERT_NEXT(a_result_after_wb, r_state == S_WR2, o_valid, "result strobe missing")
    `ARAC_ASSERT_SAME(a_page_zero_on_err, o_valid && o_status != arac_pkg::ST_OK, o_alloc_page == '0, "page set on failed request")
    `ARAC_ASSERT_SAME(a_scan_only, r_v2, r_state == S_SCAN, "scan data outside scan")
    `ARAC_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "request not taken")

endmodule

FILE: sv/arac_cmp.sv
// Per-entry compare unit used on every step of the table scan
module arac_cmp (
    input  logic [1:0]                    i_mode,
    input  logic                          i_entry_valid,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_fs,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_fe,
    input  logic [arac_pkg::PAGE_BITS:0]   i_a,
    input  logic                          i_a_over,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_s,
    input  logic [arac_pkg::PAGE_BITS:0]   i_e,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_len,
    input  logic                          i_best_found,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_best_s,
    input  logic                          i_lo_found,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_lo_s,
    input  logic                          i_hi_found,
    input  logic [arac_pkg::PAGE_BITS-1:0] i_hi_s,
    output arac_pkg::t_cmp_flags          o_flags,
    output logic [arac_pkg::PAGE_BITS-1:0] o_a_start,
    output logic [arac_pkg::PAGE_BITS-1:0] o_a_end
);

    logic [arac_pkg::PAGE_BITS+1:0] aend;
    logic                           fit;
    logic                           ge;

    always_comb begin
        aend = {1'b0, i_a} + {2'b00, i_len};
        if (i_mode == arac_pkg::MODE_FIRST) begin
            // len is non-zero, so a fitting end also implies a below the old end
            fit       = !i_a_over && (aend <= {2'b00, i_fe});
            o_a_start = i_a[arac_pkg::PAGE_BITS-1:0];
            o_a_end   = aend[arac_pkg::PAGE_BITS-1:0];
        end else begin
            fit       = (i_s >= i_fs) && (i_e <= {1'b0, i_fe});
            o_a_start = i_s;
            o_a_end   = i_e[arac_pkg::PAGE_BITS-1:0];
        end
        ge = i_fs >= i_s;
        o_flags.sel    = i_entry_valid && fit && (!i_best_found || i_fs < i_best_s);
        o_flags.hi_upd = i_entry_valid && ge && (!i_hi_found || i_fs < i_hi_s);
        o_flags.lo_upd = i_entry_valid && !ge && (!i_lo_found || i_fs > i_lo_s);
    end

endmodule
